[design/tlbp_pkg.sv]
// Shared types and constants for the two-level branch predictor.
package tlbp_pkg;

   localparam int BtbEntries     = 32;
   localparam int BtbIdxBits     = $clog2(BtbEntries);
   localparam int MaxHistoryBits = 8;
   localparam int MaxTagBits     = 30;
   localparam int AddrBits       = 32;
   localparam int TblSize        = 1 << MaxHistoryBits;
   localparam int RowBits        = 2 * TblSize;
   localparam int MaxIdxBits     = 5;

   // register indexes of the configuration port
   localparam logic [2:0] REG_BTB_INDEX_BITS = 3'd0;
   localparam logic [2:0] REG_HISTORY_BITS   = 3'd1;
   localparam logic [2:0] REG_TAG_BITS       = 3'd2;
   localparam logic [2:0] REG_INIT_COUNTER   = 3'd3;
   localparam logic [2:0] REG_GLOBAL_HIST    = 3'd4;
   localparam logic [2:0] REG_GLOBAL_TABLE   = 3'd5;
   localparam logic [2:0] REG_SHARE_MODE     = 3'd6;

   // share modes
   localparam logic [1:0] SHARE_NONE = 2'd0;
   localparam logic [1:0] SHARE_PC2  = 2'd1;
   localparam logic [1:0] SHARE_PC16 = 2'd2;

   typedef struct packed {
      logic [MaxTagBits-1:0]     tag;
      logic [AddrBits-1:0]       target;
      logic [MaxHistoryBits-1:0] hist;
   } tlbp_entry_type;

   typedef struct packed {
      logic                      wr_en;
      logic [BtbIdxBits-1:0]     wr_idx;
      tlbp_entry_type            wr_data;
   } tlbp_btb_wr_type;

   typedef struct packed {
      logic                      shared_en;
      logic [MaxHistoryBits-1:0] cidx;
      logic [1:0]                shared_data;
      logic                      row_en;
      logic [BtbIdxBits-1:0]     row;
      logic [RowBits-1:0]        row_data;
   } tlbp_ctr_wr_type;

endpackage

[design/tlbp_btb.sv]
// Branch target buffer: entry memory with per-entry valid flops.
module tlbp_btb
   import tlbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic                  rd_en,
   input  logic [BtbIdxBits-1:0] rd_idx,
   input  tlbp_btb_wr_type       wr,
   output tlbp_entry_type        rd_data,
   output logic                  rd_valid
);

   tlbp_entry_type          mem [BtbEntries];
   tlbp_entry_type          rd_data_ff;
   logic                    rd_valid_ff;
   logic [BtbEntries-1:0]   valid_ff;

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         mem[wr.wr_idx] <= wr.wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.wr_en) begin
            valid_ff[wr.wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

[design/tlbp_ctr.sv]
// Counter storage: shared counter table and per-entry counter rows.
module tlbp_ctr
   import tlbp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  logic                      rd_en,
   input  logic [MaxHistoryBits-1:0] rd_cidx,
   input  logic [BtbIdxBits-1:0]     rd_row,
   input  tlbp_ctr_wr_type           wr,
   output logic [1:0]                shared_data,
   output logic                      shared_valid,
   output logic [RowBits-1:0]        row_data,
   output logic                      row_valid
);

   logic [1:0]         shared_mem [TblSize];
   logic [RowBits-1:0] row_mem    [BtbEntries];
   logic [1:0]         shared_data_ff;
   logic [RowBits-1:0] row_data_ff;
   logic [TblSize-1:0]    shared_valid_ff;
   logic [BtbEntries-1:0] row_valid_ff;
   logic                  shared_rvalid_ff;
   logic                  row_rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr.shared_en) begin
         shared_mem[wr.cidx] <= wr.shared_data;
      end
      if (wr.row_en) begin
         row_mem[wr.row] <= wr.row_data;
      end
      if (rd_en) begin
         shared_data_ff <= shared_mem[rd_cidx];
         row_data_ff    <= row_mem[rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         shared_valid_ff  <= '0;
         row_valid_ff     <= '0;
         shared_rvalid_ff <= 1'b0;
         row_rvalid_ff    <= 1'b0;
      end else begin
         if (wr.shared_en) begin
            shared_valid_ff[wr.cidx] <= 1'b1;
         end
         if (wr.row_en) begin
            row_valid_ff[wr.row] <= 1'b1;
         end
         if (rd_en) begin
            shared_rvalid_ff <= shared_valid_ff[rd_cidx];
            row_rvalid_ff    <= row_valid_ff[rd_row];
         end
      end
   end

   assign shared_data  = shared_data_ff;
   assign shared_valid = shared_rvalid_ff;
   assign row_data     = row_data_ff;
   assign row_valid    = row_rvalid_ff;

endmodule

[design/two_level_branch_predictor.sv]
// Top level of the two-level branch predictor with BTB and gshare option.
// The edge that accepts a branch (start high, busy low) issues a synchronous read of the BTB
// entry memory. In the next cycle busy is high, the hit and the active history are formed
// from the entry, and the counter memories are read at the resulting index. This second
// read is needed because a per-entry history, or a miss that clears it, picks the counter.
// While upd_ff is high the prediction is formed, and the entry, counter and history are
// written back at the edge that ends that cycle. The result is driven for one cycle after
// that edge, marked by rsp_valid, and the next branch can be accepted at the edge that ends
// the result cycle, so no new branch is accepted before the previous one is through. The
// receiver cannot stall. A configuration register write re-initializes valid bits,
// histories and counters at once (valid flops, no clearing pass); the running counts are
// kept.
module two_level_branch_predictor
   import tlbp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // branch channel
   input  logic                start,
   output logic                busy,
   input  logic [AddrBits-1:0] req_branch_pc,
   input  logic [AddrBits-1:0] req_actual_target,
   input  logic                req_was_taken,
   // result channel
   output logic                rsp_valid,
   output logic                rsp_predicted_taken,
   output logic [AddrBits-1:0] rsp_predicted_target,
   output logic                rsp_mispredicted,
   output logic [31:0]         rsp_flush_count,
   output logic [31:0]         rsp_branch_count,
   // configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   // configuration registers
   logic [2:0] btb_index_bits_ff;
   logic [3:0] history_bits_ff;
   logic [4:0] tag_bits_ff;
   logic [1:0] init_ctr_ff;
   logic       global_hist_ff;
   logic       global_table_ff;
   logic [1:0] share_mode_ff;

   logic       cfg_wr;
   logic [2:0] cfg_idx;
   logic       cfg_hit;

   // saturated sizes and masks
   logic [2:0]                ib;
   logic [3:0]                hb;
   logic [4:0]                tb;
   logic [BtbIdxBits-1:0]     imask;
   logic [MaxHistoryBits-1:0] hmask;
   logic [MaxTagBits-1:0]     tmask;

   // accept-side
   logic                      accept;
   logic [BtbIdxBits-1:0]     idx_in;
   logic [MaxTagBits-1:0]     tag_in;

   // item in flight
   logic                      ctr_rd_ff;   // entry data back, counter read issued
   logic                      upd_ff;      // counter data back, write-back
   logic [AddrBits-1:0]       pc_ff;
   logic [AddrBits-1:0]       act_ff;
   logic                      taken_ff;
   logic [BtbIdxBits-1:0]     idx_ff;
   logic [MaxTagBits-1:0]     tag_ff;
   logic [MaxHistoryBits-1:0] cidx;
   logic [MaxHistoryBits-1:0] shared_hist_ff;

   // memory read data
   tlbp_entry_type     ent;
   logic               ent_valid;
   logic [1:0]         sc_data;
   logic               sc_valid;
   logic [RowBits-1:0] row_data;
   logic               row_valid;

   // update-side
   logic                      hit;
   logic [MaxHistoryBits-1:0] hist;
   logic [MaxHistoryBits-1:0] hist_next;
   logic [RowBits-1:0]        row_eff;
   logic [RowBits-1:0]        row_next;
   logic [1:0]                ctr;
   logic [1:0]                ctr_next;
   logic                      pred;
   logic [AddrBits-1:0]       seq;
   logic [AddrBits-1:0]       dst;
   logic                      mis;
   tlbp_btb_wr_type           btb_wr;
   tlbp_ctr_wr_type           ctr_wr;

   // result registers
   logic                rsp_valid_ff;
   logic                rsp_taken_ff;
   logic [AddrBits-1:0] rsp_target_ff;
   logic                rsp_mis_ff;
   logic [31:0]         flush_total_ff;
   logic [31:0]         branch_total_ff;

   // ---------------- configuration ----------------
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = paddr[4:2];
   assign cfg_hit = cfg_wr && (cfg_idx <= REG_SHARE_MODE);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         btb_index_bits_ff <= 3'd0;
         history_bits_ff   <= 4'd1;
         tag_bits_ff       <= 5'd0;
         init_ctr_ff       <= 2'd1;
         global_hist_ff    <= 1'b1;
         global_table_ff   <= 1'b1;
         share_mode_ff     <= SHARE_NONE;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_BTB_INDEX_BITS: btb_index_bits_ff <= pwdata[2:0];
            REG_HISTORY_BITS:   history_bits_ff   <= pwdata[3:0];
            REG_TAG_BITS:       tag_bits_ff       <= pwdata[4:0];
            REG_INIT_COUNTER:   init_ctr_ff       <= pwdata[1:0];
            REG_GLOBAL_HIST:    global_hist_ff    <= pwdata[0];
            REG_GLOBAL_TABLE:   global_table_ff   <= pwdata[0];
            REG_SHARE_MODE:     share_mode_ff     <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (cfg_idx)
         REG_BTB_INDEX_BITS: prdata = {29'd0, btb_index_bits_ff};
         REG_HISTORY_BITS:   prdata = {28'd0, history_bits_ff};
         REG_TAG_BITS:       prdata = {27'd0, tag_bits_ff};
         REG_INIT_COUNTER:   prdata = {30'd0, init_ctr_ff};
         REG_GLOBAL_HIST:    prdata = {31'd0, global_hist_ff};
         REG_GLOBAL_TABLE:   prdata = {31'd0, global_table_ff};
         REG_SHARE_MODE:     prdata = {30'd0, share_mode_ff};
         default:            prdata = '0;
      endcase
   end

   // sizes saturate at their maxima
   assign ib    = (btb_index_bits_ff > 3'(MaxIdxBits)) ? 3'(MaxIdxBits) : btb_index_bits_ff;
   assign hb    = (history_bits_ff > 4'(MaxHistoryBits)) ? 4'(MaxHistoryBits)
                                                        : history_bits_ff;
   assign tb    = (tag_bits_ff > 5'(MaxTagBits)) ? 5'(MaxTagBits) : tag_bits_ff;
   assign imask = BtbIdxBits'(({{BtbIdxBits{1'b0}}, 1'b1} << ib) - 1'b1);
   assign hmask = MaxHistoryBits'(({{MaxHistoryBits{1'b0}}, 1'b1} << hb) - 1'b1);
   assign tmask = MaxTagBits'(({{MaxTagBits{1'b0}}, 1'b1} << tb) - 1'b1);

   // ---------------- accept / entry read ----------------
   assign accept = start && !busy;
   assign busy   = ctr_rd_ff || upd_ff;
   assign idx_in = req_branch_pc[2 +: BtbIdxBits] & imask;
   assign tag_in = MaxTagBits'(req_branch_pc[AddrBits-1:2] >> ib) & tmask;

   always_ff @(posedge clock) begin
      if (accept) begin
         pc_ff    <= req_branch_pc;
         act_ff   <= req_actual_target;
         taken_ff <= req_was_taken;
         idx_ff   <= idx_in;
         tag_ff   <= tag_in;
      end
   end

   tlbp_btb u_btb (
      .clock    (clock),
      .reset    (reset),
      .clear    (cfg_hit),
      .rd_en    (accept),
      .rd_idx   (idx_in),
      .wr       (btb_wr),
      .rd_data  (ent),
      .rd_valid (ent_valid)
   );

   // ---------------- history and counter read ----------------
   assign hit = ent_valid && (ent.tag == tag_ff);
   assign seq = pc_ff + 32'd4;

   // in per-entry history mode, a missed entry starts from a cleared history
   always_comb begin
      if (global_hist_ff) begin
         hist = shared_hist_ff & hmask;
      end else begin
         hist = hit ? (ent.hist & hmask) : '0;
      end
   end

   // index into the shared table: the history, XORed with PC bits in the gshare modes
   always_comb begin
      cidx = hist;
      case (share_mode_ff)
         SHARE_PC2:  cidx = hist ^ (pc_ff[2 +: MaxHistoryBits] & hmask);
         SHARE_PC16: cidx = hist ^ (pc_ff[16 +: MaxHistoryBits] & hmask);
         default:    cidx = hist;
      endcase
   end

   tlbp_ctr u_ctr (
      .clock        (clock),
      .reset        (reset),
      .clear        (cfg_hit),
      .rd_en        (ctr_rd_ff),
      .rd_cidx      (cidx),
      .rd_row       (idx_ff),
      .wr           (ctr_wr),
      .shared_data  (sc_data),
      .shared_valid (sc_valid),
      .row_data     (row_data),
      .row_valid    (row_valid)
   );

   // ---------------- predict and update ----------------
   always_comb begin
      // a missed entry reloads its row
      row_eff = (hit && row_valid) ? row_data : {TblSize{init_ctr_ff}};
      if (global_table_ff) begin
         ctr = sc_valid ? sc_data : init_ctr_ff;
      end else begin
         ctr = row_eff[{hist, 1'b0} +: 2];
      end
      if (taken_ff) begin
         ctr_next = (ctr == 2'd3) ? 2'd3 : ctr + 2'd1;
      end else begin
         ctr_next = (ctr == 2'd0) ? 2'd0 : ctr - 2'd1;
      end
      row_next = row_eff;
      row_next[{hist, 1'b0} +: 2] = ctr_next;
      hist_next = {hist[MaxHistoryBits-2:0], taken_ff} & hmask;
      pred = hit && ctr[1];
      dst  = pred ? ent.target : seq;
      mis  = taken_ff ? (dst != act_ff) : (dst != seq);
   end

   always_comb begin
      btb_wr.wr_en          = upd_ff;
      btb_wr.wr_idx         = idx_ff;
      btb_wr.wr_data.tag    = tag_ff;
      btb_wr.wr_data.target = act_ff;
      btb_wr.wr_data.hist   = hist_next;
      ctr_wr.shared_en      = upd_ff && global_table_ff;
      ctr_wr.cidx           = cidx;
      ctr_wr.shared_data    = ctr_next;
      ctr_wr.row_en         = upd_ff && !global_table_ff;
      ctr_wr.row            = idx_ff;
      ctr_wr.row_data       = row_next;
   end

   // control, history and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_rd_ff       <= 1'b0;
         upd_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         shared_hist_ff  <= '0;
         flush_total_ff  <= '0;
         branch_total_ff <= '0;
      end else begin
         ctr_rd_ff    <= accept;
         upd_ff       <= ctr_rd_ff;
         rsp_valid_ff <= upd_ff;
         if (cfg_hit) begin
            shared_hist_ff <= '0;
         end else if (upd_ff && global_hist_ff) begin
            shared_hist_ff <= hist_next;
         end
         if (upd_ff) begin
            branch_total_ff <= branch_total_ff + 32'd1;
            if (mis) begin
               flush_total_ff <= flush_total_ff + 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd_ff) begin
         rsp_taken_ff  <= pred;
         rsp_target_ff <= dst;
         rsp_mis_ff    <= mis;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_predicted_taken  = rsp_taken_ff;
   assign rsp_predicted_target = rsp_target_ff;
   assign rsp_mispredicted     = rsp_mis_ff;
   assign rsp_flush_count      = flush_total_ff;
   assign rsp_branch_count     = branch_total_ff;

endmodule
